FILE: rtl/core/mcf_pkg.sv
// Package for the motor command framer: frame descriptor type, operation
// codes and clamp limits. Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package mcf_pkg;

    // Digit geometry of the frame payload.
    localparam int DigitW   = 7;
    localparam int MaxDigit = 9;
    localparam int PayloadW = DigitW * MaxDigit;
    localparam int CountW   = 4;

    // Operation codes carried in the header.
    typedef enum logic [2:0] {
        OP_VOLTAGE     = 3'd0,
        OP_ANGLE_POWER = 3'd1,
        OP_ANGLE_SPEED = 3'd2,
        OP_SPEED       = 3'd3,
        OP_ANGLE_GAINS = 3'd4,
        OP_SPEED_GAINS = 3'd5,
        OP_INVERT      = 3'd6
    } t_op;

    // Clamp bounds and offsets.
    localparam logic signed [31:0] VoltLim   = 32'sd950;
    localparam logic signed [31:0] VoltOfs   = 32'sd1000;
    localparam logic signed [31:0] AngleMax  = 32'sh07FF_FFFF;
    localparam logic signed [31:0] AngleOfs  = 32'sh0800_0000;
    localparam logic signed [31:0] PowerLim  = 32'sd950;
    localparam logic signed [31:0] SpdLimMax = 32'sd16383;
    localparam logic signed [31:0] SpeedMax  = 32'sh000F_FFFF;
    localparam logic signed [31:0] SpeedOfs  = 32'sh0010_0000;
    localparam logic signed [31:0] GainMax   = 32'sd2097151;

    // Checksum seed and header marker.
    localparam logic [6:0] SumSeed    = 7'd6;
    localparam logic       HeaderMark = 1'b1;

    // One classified command waiting to be serialized.
    typedef struct packed {
        logic [7:0]          header;
        logic [PayloadW-1:0] payload;
        logic [CountW-1:0]   digits;
    } t_frame;

endpackage

`default_nettype wire

FILE: rtl/core/motor_command_framer.sv
// Top level of the motor command framer: front end, frame queue and back
// end. Depends on mcf_pkg, mcf_front, mcf_queue and mcf_back.
//
// Usage: a command (operation, id, target, drive, three gains) is
// transferred on the input channel (i_valid/o_ready). The output channel
// (o_valid/i_ready) then carries its frame one byte per transfer: header,
// 7-bit payload digits least significant first, and a checksum byte with
// o_last set. Frames are 3 to 11 bytes; the gain commands are 11.
// The header reaches the output register after the command has been written
// into the frame queue, when the serializer is free. Throughput: one byte per
// cycle while i_ready is high, set by the single-byte output register, and
// frames follow each other with no gap.
// A two-entry frame queue sits between the command front end and the
// serializer; o_ready falls only while both entries are occupied.
// Operation code 7 is transferred and produces no bytes.
// Reset (synchronous, active low) empties the queue and the output register.
// When the receiver stalls, the current byte holds and the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module motor_command_framer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_operation,
    input  wire logic [3:0]         i_id,
    input  wire logic signed [31:0] i_target,
    input  wire logic signed [31:0] i_drive,
    input  wire logic signed [31:0] i_gain_p,
    input  wire logic signed [31:0] i_gain_i,
    input  wire logic signed [31:0] i_gain_d,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [7:0]              o_frame_byte,
    output logic                    o_last
);
    import mcf_pkg::*;

    t_frame w_front_frame;
    t_frame w_queue_frame;
    logic   w_push_req;
    logic   w_full;
    logic   w_nonempty;
    logic   w_pop;

    // Command classification.
    mcf_front u_front (
        .i_operation (i_operation),
        .i_id        (i_id),
        .i_target    (i_target),
        .i_drive     (i_drive),
        .i_gain_p    (i_gain_p),
        .i_gain_i    (i_gain_i),
        .i_gain_d    (i_gain_d),
        .o_frame     (w_front_frame),
        .o_push_req  (w_push_req)
    );

    assign o_ready = !w_full;

    // Decoupling queue.
    mcf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_valid && o_ready && w_push_req),
        .i_data     (w_front_frame),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_data     (w_queue_frame),
        .o_nonempty (w_nonempty)
    );

    // Byte serializer.
    mcf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (w_queue_frame),
        .i_frame_valid (w_nonempty),
        .o_frame_pop   (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_frame_byte  (o_frame_byte),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

FILE: rtl/core/mcf_front.sv
// Front end of the motor command framer: clamps and offsets the command
// fields and packs them into a frame descriptor. Depends on mcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcf_front (
    input  wire logic [2:0]         i_operation,
    input  wire logic [3:0]         i_id,
    input  wire logic signed [31:0] i_target,
    input  wire logic signed [31:0] i_drive,
    input  wire logic signed [31:0] i_gain_p,
    input  wire logic signed [31:0] i_gain_i,
    input  wire logic signed [31:0] i_gain_d,
    output mcf_pkg::t_frame         o_frame,
    output logic                    o_push_req
);
    import mcf_pkg::*;

    // Gain clamp to 0..2097151.
    function automatic logic [20:0] clamp_gain(input logic signed [31:0] g);
        logic [20:0] r;
        if (g < 32'sd0) begin
            r = 21'd0;
        end else if (g > GainMax) begin
            r = 21'h1F_FFFF;
        end else begin
            r = g[20:0];
        end
        return r;
    endfunction

    logic signed [31:0] w_volt_cl;
    logic signed [31:0] w_volt_sum;
    logic signed [31:0] w_angle_sum;
    logic signed [31:0] w_speed_sum;
    logic [10:0]        w_volt;
    logic [27:0]        w_angle;
    logic [20:0]        w_speed;
    logic [13:0]        w_limit;
    logic signed [31:0] w_lim_max;

    // Voltage: clamp to +-950, then offset by 1000.
    always_comb begin
        if (i_drive < -VoltLim) begin
            w_volt_cl = -VoltLim;
        end else if (i_drive > VoltLim) begin
            w_volt_cl = VoltLim;
        end else begin
            w_volt_cl = i_drive;
        end
        w_volt_sum = w_volt_cl + VoltOfs;
        w_volt     = w_volt_sum[10:0];
    end

    // Angle: clamp to 28-bit signed range, then offset to unsigned.
    always_comb begin
        w_angle_sum = i_target + AngleOfs;
        if (i_target < -AngleOfs) begin
            w_angle = 28'd0;
        end else if (i_target > AngleMax) begin
            w_angle = 28'hFFF_FFFF;
        end else begin
            w_angle = w_angle_sum[27:0];
        end
    end

    // Speed: clamp to 21-bit signed range, then offset to unsigned.
    always_comb begin
        w_speed_sum = i_target + SpeedOfs;
        if (i_target < -SpeedOfs) begin
            w_speed = 21'd0;
        end else if (i_target > SpeedMax) begin
            w_speed = 21'h1F_FFFF;
        end else begin
            w_speed = w_speed_sum[20:0];
        end
    end

    // Power or speed limit that follows the angle.
    always_comb begin
        w_lim_max = (t_op'(i_operation) == OP_ANGLE_POWER) ? PowerLim : SpdLimMax;
        if (i_drive < 32'sd0) begin
            w_limit = 14'd0;
        end else if (i_drive > w_lim_max) begin
            w_limit = w_lim_max[13:0];
        end else begin
            w_limit = i_drive[13:0];
        end
    end

    // Classify the operation and pack payload digits, least significant first.
    always_comb begin
        o_frame.header  = {HeaderMark, i_operation, i_id};
        o_frame.payload = '0;
        o_frame.digits  = '0;
        o_push_req      = 1'b1;
        unique case (t_op'(i_operation))
            OP_VOLTAGE: begin
                o_frame.payload = PayloadW'({3'd0, w_volt});
                o_frame.digits  = CountW'(2);
            end
            OP_ANGLE_POWER, OP_ANGLE_SPEED: begin
                o_frame.payload = PayloadW'({w_limit, w_angle});
                o_frame.digits  = CountW'(6);
            end
            OP_SPEED: begin
                o_frame.payload = PayloadW'(w_speed);
                o_frame.digits  = CountW'(3);
            end
            OP_ANGLE_GAINS, OP_SPEED_GAINS: begin
                o_frame.payload = {clamp_gain(i_gain_d), clamp_gain(i_gain_i),
                                   clamp_gain(i_gain_p)};
                o_frame.digits  = CountW'(9);
            end
            OP_INVERT: begin
                o_frame.payload = PayloadW'(i_drive[0]);
                o_frame.digits  = CountW'(1);
            end
            default: begin
                // Unused code: the command is taken and dropped.
                o_push_req = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/mcf_queue.sv
// Two-entry frame descriptor queue between the front and back ends of the
// motor command framer. Depends on mcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcf_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire mcf_pkg::t_frame i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output mcf_pkg::t_frame      o_data,
    output logic                 o_nonempty
);
    import mcf_pkg::*;

    t_frame     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full     = (r_count == 2'd2);
    assign o_nonempty = (r_count != 2'd0);
    assign o_data     = r_mem[r_rd_ptr];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // A push never lands on a full queue and a pop never on an empty one.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full frame queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_nonempty |-> !i_pop)
        else $error("pop from empty frame queue");

    // With one entry occupied, the pointers differ.
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr))
        else $error("frame queue pointers disagree with count");

endmodule

`default_nettype wire

FILE: rtl/core/mcf_back.sv
// Back end of the motor command framer: serializes one frame descriptor as
// header, digits and checksum into an output register. Depends on mcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcf_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mcf_pkg::t_frame i_frame,
    input  wire logic            i_frame_valid,
    output logic                 o_frame_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [7:0]           o_frame_byte,
    output logic                 o_last
);
    import mcf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DIGIT = 3'b010,
        S_CHECK = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [PayloadW-1:0] r_payload, n_payload;
    logic [CountW-1:0]   r_left, n_left;
    logic [6:0]          r_sum, n_sum;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_out_byte, n_out_byte;
    logic                r_out_last, n_out_last;
    logic                w_advance;

    // The output slot is free when empty or being transferred.
    assign w_advance   = !r_out_valid || i_ready;
    assign o_valid     = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_last      = r_out_last;

    // At most one byte is produced per free output slot.
    always_comb begin
        n_state     = r_state;
        n_payload   = r_payload;
        n_left      = r_left;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_frame_pop = 1'b0;
        if (w_advance) begin
            n_out_valid = 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_frame_valid) begin
                        o_frame_pop = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_byte  = i_frame.header;
                        n_out_last  = 1'b0;
                        n_sum       = SumSeed + i_frame.header[6:0];
                        n_payload   = i_frame.payload;
                        n_left      = i_frame.digits;
                        n_state     = S_DIGIT;
                    end
                end
                S_DIGIT: begin
                    n_out_valid = 1'b1;
                    n_out_byte  = {1'b0, r_payload[DigitW-1:0]};
                    n_out_last  = 1'b0;
                    n_sum       = r_sum + r_payload[DigitW-1:0];
                    n_payload   = {{DigitW{1'b0}}, r_payload[PayloadW-1:DigitW]};
                    n_left      = r_left - CountW'(1);
                    if (r_left == CountW'(1)) begin
                        n_state = S_CHECK;
                    end
                end
                S_CHECK: begin
                    n_out_valid = 1'b1;
                    n_out_byte  = {1'b0, r_sum};
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_payload  <= n_payload;
        r_left     <= n_left;
        r_sum      <= n_sum;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    // While digits are being sent, at least one remains.
    a_digits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT) |-> (r_left != '0))
        else $error("digit phase entered with no digits left");

    // A header is never the last byte and carries the marker bit.
    a_header_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_pop |=> (o_valid && o_frame_byte[7] && !o_last))
        else $error("header byte malformed");

    // The checksum byte, like every byte but the header, has the top bit clear.
    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !o_frame_byte[7])
        else $error("checksum byte has top bit set");

    // A new frame is taken only between frames.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_pop |=> (r_state == S_DIGIT))
        else $error("frame popped without entering digit phase");

endmodule

`default_nettype wire
